@@ rtl/mnpt_pkg.sv @@
package mnpt_pkg;

	localparam int MAX_HELD_DEF = 128;

	localparam int KEY_W      = 7;
	localparam int VEL_W      = 7;
	localparam int CHAN_W     = 5;
	localparam int MODE_W     = 2;
	localparam int ENTRY_W    = KEY_W + VEL_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int IN_W       = 24;
	localparam int OUT_W      = 16;

	localparam logic [CHAN_W-1:0] CHAN_RST     = 5'd1;
	localparam logic [KEY_W-1:0]  KEY_LOW_RST  = 7'd0;
	localparam logic [KEY_W-1:0]  KEY_HIGH_RST = 7'd127;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL,
		CFG_KEY_LOW,
		CFG_KEY_HIGH,
		CFG_MODE
	} cfg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_FIRST,
		MODE_LAST,
		MODE_LOW,
		MODE_HIGH
	} mode_t;

	localparam mode_t MODE_RST = MODE_LAST;

	typedef enum logic [1:0] {
		SCAN_FIND,
		SCAN_SHIFT,
		SCAN_BEST
	} scan_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FIND,
		ST_SHIFT,
		ST_ROOM,
		ST_DROP,
		ST_WINSTART,
		ST_BEST,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic     accept;
		logic     start;
		scan_op_t op;
		logic     drop;
		logic     append;
		logic     report;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic note_on;
		logic clear;
		logic found;
		logic full;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/mono_note_priority_tracker_top.sv @@
// Monophonic note-priority tracker.
// Slave stream s_*: one transaction per note item (clear, note event fields).
// Master stream m_*: at most one transaction per item, carrying the winning
// key and velocity with change flags; none when the item left the list alone.
// cfg_we/cfg_addr/cfg_wdata: channel, key range and priority mode, written
// only while the block is idle, a rule on the user that the block itself does not enforce.
// One item at a time: the next item is taken only when the last one is done.
// The held list sits in a memory with one read and one write port,
// scanned one entry per cycle for the key search, the shift that closes
// the gap of a removed entry and, under lowest or highest priority, the
// winner search.
// Reset empties the list, zeroes the last reported key and velocity and
// loads the register defaults; no clearing pass is needed.
// A stalled result holds in the output register; the next item is still
// accepted and worked on, and its result waits until the register frees,
// holding s_tready low meanwhile.
module mono_note_priority_tracker_top #(
	parameter int MAX_HELD = mnpt_pkg::MAX_HELD_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// clear, note_present, note_channel, note_on, note_key, note_velocity
	input  logic [mnpt_pkg::IN_W-1:0]       s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// winner_key, winner_velocity, key_changed, velocity_changed
	output logic [mnpt_pkg::OUT_W-1:0]      m_tdata,
	input  logic                            cfg_we,
	input  logic [mnpt_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [mnpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mnpt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mnpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mnpt_dpath #(
		.MAX_HELD (MAX_HELD)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule

@@ rtl/mnpt_ctrl.sv @@
module mnpt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mnpt_pkg::sts_t sts,
	output mnpt_pkg::cmd_t cmd
);
	import mnpt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.hit) state_d = ST_FIND;
				else if (sts.clear) state_d = ST_BEST;
				else state_d = ST_IDLE;
			end
			ST_FIND: begin
				if (sts.done) begin
					if (sts.found) state_d = ST_SHIFT;
					else if (sts.note_on) state_d = ST_ROOM;
					else if (sts.clear) state_d = ST_BEST;
					else state_d = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				if (sts.done) state_d = sts.note_on ? ST_ROOM : ST_BEST;
			end
			ST_ROOM: begin
				state_d = sts.full ? ST_DROP : ST_WINSTART;
			end
			ST_DROP: begin
				if (sts.done) state_d = ST_ROOM;
			end
			ST_WINSTART: begin
				state_d = ST_BEST;
			end
			ST_BEST: begin
				if (sts.done) state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = SCAN_FIND;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_DECIDE: begin
				if (sts.hit) begin
					cmd.start = 1'b1;
					cmd.op    = SCAN_FIND;
				end else if (sts.clear) begin
					cmd.start = 1'b1;
					cmd.op    = SCAN_BEST;
				end
			end
			ST_FIND: begin
				if (sts.done && sts.found) begin
					cmd.start = 1'b1;
					cmd.op    = SCAN_SHIFT;
				end else if (sts.done && !sts.note_on && sts.clear) begin
					cmd.start = 1'b1;
					cmd.op    = SCAN_BEST;
				end
			end
			ST_SHIFT: begin
				if (sts.done && !sts.note_on) begin
					cmd.start = 1'b1;
					cmd.op    = SCAN_BEST;
				end
			end
			ST_ROOM: begin
				if (sts.full) begin
					cmd.start = 1'b1;
					cmd.op    = SCAN_SHIFT;
					cmd.drop  = 1'b1;
				end else begin
					cmd.append = 1'b1;
				end
			end
			ST_WINSTART: begin
				cmd.start = 1'b1;
				cmd.op    = SCAN_BEST;
			end
			ST_REPORT: begin
				cmd.report = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/mnpt_dpath.sv @@
module mnpt_dpath #(
	parameter int MAX_HELD = mnpt_pkg::MAX_HELD_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mnpt_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [mnpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [mnpt_pkg::IN_W-1:0]       in_data,
	input  mnpt_pkg::cmd_t                  cmd,
	output mnpt_pkg::sts_t                  sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [mnpt_pkg::OUT_W-1:0]      out_data
);
	import mnpt_pkg::*;

	localparam int IW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
	localparam int CW = $clog2(MAX_HELD + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HELD);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [IW-1:0] ONE_I   = IW'(1);

	logic [CHAN_W-1:0] chan_q;
	logic [KEY_W-1:0]  klo_q;
	logic [KEY_W-1:0]  khi_q;
	mode_t             mode_q;

	logic              clr_q;
	logic              hit_q;
	logic              on_q;
	logic [KEY_W-1:0]  key_q;
	logic [VEL_W-1:0]  vel_q;

	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     idx_q;
	logic              found_q;

	logic [CW-1:0]     scan_q;
	logic [CW-1:0]     end_q;
	logic              run_q;
	scan_op_t          op_q;

	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic [ENTRY_W-1:0] rd_s1;

	logic              best_vld_q;
	logic [KEY_W-1:0]  best_key_q;
	logic [VEL_W-1:0]  best_vel_q;

	logic [KEY_W-1:0]  last_key_q;
	logic [VEL_W-1:0]  last_vel_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [ENTRY_W-1:0] mem [MAX_HELD];

	logic              in_clr;
	logic              in_present;
	logic [CHAN_W-1:0] in_chan;
	logic              in_on;
	logic [KEY_W-1:0]  in_key;
	logic [VEL_W-1:0]  in_vel;
	logic              in_hit;

	logic              rd_en;
	logic [KEY_W-1:0]  rd_key;
	logic              take;
	logic [CW-1:0]     shift_lo;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic              empty;

	assign in_clr     = in_data[0];
	assign in_present = in_data[1];
	assign in_chan    = in_data[6:2];
	assign in_on      = in_data[7];
	assign in_key     = in_data[14:8];
	assign in_vel     = in_data[21:15];
	assign in_hit     = in_present && (in_chan == chan_q) && (in_key >= klo_q) &&
	                    (in_key <= khi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= CHAN_RST;
			klo_q  <= KEY_LOW_RST;
			khi_q  <= KEY_HIGH_RST;
			mode_q <= MODE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_CHANNEL:  chan_q <= cfg_wdata[CHAN_W-1:0];
				CFG_KEY_LOW:  klo_q  <= cfg_wdata[KEY_W-1:0];
				CFG_KEY_HIGH: khi_q  <= cfg_wdata[KEY_W-1:0];
				CFG_MODE:     mode_q <= mode_t'(cfg_wdata[MODE_W-1:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b0;
			hit_q <= 1'b0;
			on_q  <= 1'b0;
		end else if (cmd.accept) begin
			clr_q <= in_clr;
			hit_q <= in_hit;
			on_q  <= in_on;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= in_key;
			vel_q <= in_vel;
		end
	end

	assign rd_key   = rd_s1[ENTRY_W-1:VEL_W];
	assign rd_en    = run_q && (scan_q != end_q);
	assign shift_lo = cmd.drop ? ONE_C : (CW'(idx_q) + ONE_C);
	assign empty    = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.accept && in_clr) begin
			cnt_q <= '0;
		end else if (cmd.start && cmd.op == SCAN_SHIFT) begin
			cnt_q <= cnt_q - ONE_C;
		end else if (cmd.append) begin
			cnt_q <= cnt_q + ONE_C;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			scan_q <= '0;
			end_q  <= '0;
			op_q   <= SCAN_FIND;
		end else if (cmd.start) begin
			run_q <= 1'b1;
			op_q  <= cmd.op;
			end_q <= cnt_q;
			case (cmd.op)
				SCAN_FIND: begin
					scan_q <= '0;
				end
				SCAN_SHIFT: begin
					scan_q <= shift_lo;
				end
				SCAN_BEST: begin
					scan_q <= '0;
					if (mode_q == MODE_FIRST) begin
						end_q <= empty ? '0 : ONE_C;
					end else if (mode_q == MODE_LAST) begin
						scan_q <= empty ? '0 : (cnt_q - ONE_C);
					end
				end
				default: begin
					scan_q <= '0;
				end
			endcase
		end else if (run_q) begin
			if (scan_q == end_q) run_q <= 1'b0;
			else scan_q <= scan_q + ONE_C;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1  <= mem[scan_q[IW-1:0]];
			idx_s1 <= scan_q[IW-1:0];
		end
	end

	assign wr_en   = (vld_s1 && op_q == SCAN_SHIFT) || cmd.append;
	assign wr_addr = cmd.append ? cnt_q[IW-1:0] : (idx_s1 - ONE_I);
	assign wr_data = cmd.append ? {key_q, vel_q} : rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			idx_q   <= '0;
		end else if (cmd.start && cmd.op == SCAN_FIND) begin
			found_q <= 1'b0;
		end else if (cmd.drop) begin
			idx_q <= '0;
		end else if (vld_s1 && op_q == SCAN_FIND && rd_key == key_q) begin
			found_q <= 1'b1;
			idx_q   <= idx_s1;
		end
	end

	assign take = !best_vld_q ||
	              (mode_q == MODE_LOW && rd_key < best_key_q) ||
	              (mode_q == MODE_HIGH && rd_key > best_key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
		end else if (cmd.start && cmd.op == SCAN_BEST) begin
			best_vld_q <= 1'b0;
		end else if (vld_s1 && op_q == SCAN_BEST) begin
			best_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && op_q == SCAN_BEST && take) begin
			best_key_q <= rd_key;
			best_vel_q <= rd_s1[VEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q  <= '0;
			last_vel_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.report) begin
			out_valid_q <= 1'b1;
			if (empty) begin
				last_vel_q <= '0;
			end else begin
				last_key_q <= best_key_q;
				last_vel_q <= best_vel_q;
			end
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.report) begin
			if (empty) begin
				out_data_q <= {1'b1, 1'b0, {VEL_W{1'b0}}, last_key_q};
			end else begin
				out_data_q <= {best_vel_q != last_vel_q, best_key_q != last_key_q,
				               best_vel_q, best_key_q};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign sts.done     = !run_q && !vld_s1;
	assign sts.hit      = hit_q;
	assign sts.note_on  = on_q;
	assign sts.clear    = clr_q;
	assign sts.found    = found_q;
	assign sts.full     = (cnt_q >= MAX_CNT);
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

@@ rtl/mnpt_checker.sv @@
module mnpt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [mnpt_pkg::OUT_W-1:0] m_tdata
);
	import mnpt_pkg::*;

	logic [KEY_W-1:0] prev_key_q;
	logic [VEL_W-1:0] prev_vel_q;
	logic [KEY_W-1:0] o_key;
	logic [VEL_W-1:0] o_vel;
	logic             o_kc;
	logic             o_vc;

	assign o_key = m_tdata[KEY_W-1:0];
	assign o_vel = m_tdata[KEY_W+VEL_W-1:KEY_W];
	assign o_kc  = m_tdata[KEY_W+VEL_W];
	assign o_vc  = m_tdata[KEY_W+VEL_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q <= '0;
			prev_vel_q <= '0;
		end else if (m_tvalid && m_tready) begin
			prev_key_q <= o_key;
			prev_vel_q <= o_vel;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_key_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (o_kc == (o_key != prev_key_q)))
		else $error("key change flag disagrees with delivered keys");

	a_vel_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (o_vel != prev_vel_q) |-> o_vc)
		else $error("velocity change not flagged");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken before the first was handled");

endmodule

bind mono_note_priority_tracker_top mnpt_checker u_mnpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/sv/mono_note_priority_tracker_top_test.sv @@
module mono_note_priority_tracker_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mnpt_pkg::*;

	localparam int HELD_MAX = MAX_HELD_DEF;
	localparam int SETTLE_CYCLES = 3 * HELD_MAX + 16;
	localparam int LONG_HOLD = 600;
	localparam int HOLD_AFTER = 400;

	typedef struct packed {
		logic [VEL_W-1:0]  vel;
		logic [KEY_W-1:0]  key;
		logic              on;
		logic [CHAN_W-1:0] channel;
		logic              present;
		logic              clear;
	} note_t;

	typedef struct packed {
		logic             vel_chg;
		logic             key_chg;
		logic [VEL_W-1:0] vel;
		logic [KEY_W-1:0] key;
	} winner_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VEL_W-1:0] vel;
	} held_t;

	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_NONE,
		EXP_GIVEN
	} exp_kind_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_THREE_OF_FOUR,
		RX_SPARSE
	} rx_style_t;

	typedef struct {
		bit                is_cfg;
		logic [CHAN_W-1:0] ch;
		logic [KEY_W-1:0]  lo;
		logic [KEY_W-1:0]  hi;
		mode_t             mode;
		note_t             n;
		exp_kind_t         ek;
		winner_t           w;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	held_t   held_list[$];
	winner_t winner_q[$];
	logic [KEY_W-1:0]  reported_key;
	logic [VEL_W-1:0]  reported_vel;
	logic [CHAN_W-1:0] cur_channel;
	logic [KEY_W-1:0]  cur_low;
	logic [KEY_W-1:0]  cur_high;
	mode_t             cur_mode;

	int  errors;
	int  rx_count;
	int  burst_left;
	bit  calm;

	mono_note_priority_tracker_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic bit track_note(input note_t n, output winner_t w);
		bit changed;
		bit found;
		int idx;
		int win;
		changed = 0;
		found = 0;
		idx = 0;
		win = 0;
		w = '0;
		if (n.clear) begin
			held_list.delete();
			changed = 1;
		end
		if (n.present && n.channel == cur_channel && n.key >= cur_low && n.key <= cur_high) begin
			foreach (held_list[i]) begin
				if (held_list[i].key == n.key) begin
					found = 1;
					idx = i;
				end
			end
			if (!n.on) begin
				if (found) begin
					held_list.delete(idx);
					changed = 1;
				end
			end else begin
				if (found)
					held_list.delete(idx);
				if (held_list.size() >= HELD_MAX)
					held_list.delete(0);
				held_list.push_back('{key: n.key, vel: n.vel});
				changed = 1;
			end
		end
		if (!changed)
			return 0;
		if (held_list.size() == 0) begin
			reported_vel = '0;
			w = '{vel_chg: 1'b1, key_chg: 1'b0, vel: '0, key: reported_key};
			return 1;
		end
		case (cur_mode)
			MODE_FIRST: win = 0;
			MODE_LAST:  win = held_list.size() - 1;
			MODE_LOW: begin
				for (int i = 1; i < held_list.size(); i++)
					if (held_list[i].key < held_list[win].key)
						win = i;
			end
			MODE_HIGH: begin
				for (int i = 1; i < held_list.size(); i++)
					if (held_list[i].key > held_list[win].key)
						win = i;
			end
		endcase
		w.key = held_list[win].key;
		w.vel = held_list[win].vel;
		w.key_chg = (w.key != reported_key);
		w.vel_chg = (w.vel != reported_vel);
		reported_key = w.key;
		reported_vel = w.vel;
		return 1;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
		errors++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (winner_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [CHAN_W-1:0] ch, logic [KEY_W-1:0] lo,
	                          logic [KEY_W-1:0] hi, mode_t mode);
		logic [CFG_DATA_W-1:0] vals[4];
		cfg_idx_t regs[4];
		regs = '{CFG_CHANNEL, CFG_KEY_LOW, CFG_KEY_HIGH, CFG_MODE};
		vals = '{CFG_DATA_W'(ch), lo, hi, CFG_DATA_W'(mode)};
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= regs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_channel = ch;
		cur_low = lo;
		cur_high = hi;
		cur_mode = mode;
	endtask

	task automatic send_note(note_t n, exp_kind_t ek = EXP_MODEL, winner_t given = '0);
		winner_t w;
		bit has_result;
		has_result = track_note(n, w);
		if (ek == EXP_GIVEN)
			winner_q.push_back(given);
		else if (ek == EXP_MODEL && has_result)
			winner_q.push_back(w);
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - $bits(note_t)){1'b0}}, n};
		do @(posedge clk); while (!s_tready);
		if (!calm) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(8, 1)) @(posedge clk);
				burst_left = $urandom_range(20, 1);
			end else begin
				burst_left--;
			end
		end
	endtask

	function automatic plan_row_t mk_cfg(logic [CHAN_W-1:0] ch, logic [KEY_W-1:0] lo,
	                                     logic [KEY_W-1:0] hi, mode_t mode);
		plan_row_t r;
		r = '{is_cfg: 1'b1, ch: ch, lo: lo, hi: hi, mode: mode, n: '0, ek: EXP_NONE, w: '0};
		return r;
	endfunction

	function automatic plan_row_t mk_note(bit clr, bit pres, logic [CHAN_W-1:0] ch, bit on,
	                                      logic [KEY_W-1:0] key, logic [VEL_W-1:0] vel,
	                                      exp_kind_t ek = EXP_MODEL,
	                                      logic [KEY_W-1:0] wk = 0, logic [VEL_W-1:0] wv = 0,
	                                      bit kc = 0, bit vc = 0);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.ch = '0;
		r.lo = '0;
		r.hi = '0;
		r.mode = MODE_FIRST;
		r.n = '{vel: vel, key: key, on: on, channel: ch, present: pres, clear: clr};
		r.ek = ek;
		r.w = '{vel_chg: vc, key_chg: kc, vel: wv, key: wk};
		return r;
	endfunction

	task automatic run_directed();
		plan_row_t plan[$];
		plan.push_back(mk_note(1, 0, 1, 0, 0, 0, EXP_GIVEN, 0, 0, 0, 1));
		plan.push_back(mk_note(0, 1, 1, 1, 127, 127, EXP_GIVEN, 127, 127, 1, 1));
		plan.push_back(mk_note(0, 1, 1, 1, 0, 1));
		plan.push_back(mk_note(0, 1, 1, 0, 0, 0));
		plan.push_back(mk_note(0, 1, 1, 0, 127, 0, EXP_GIVEN, 127, 0, 0, 1));
		plan.push_back(mk_note(0, 1, 1, 0, 5, 0, EXP_NONE));
		plan.push_back(mk_note(0, 1, 1, 1, 64, 0, EXP_GIVEN, 64, 0, 1, 0));
		plan.push_back(mk_note(0, 1, 2, 1, 10, 50, EXP_NONE));
		plan.push_back(mk_note(0, 1, 0, 1, 10, 50, EXP_NONE));
		plan.push_back(mk_note(0, 1, 31, 1, 10, 50, EXP_NONE));
		plan.push_back(mk_note(1, 1, 1, 1, 10, 20));
		plan.push_back(mk_note(0, 1, 1, 1, 10, 20));
		plan.push_back(mk_cfg(1, 0, 127, MODE_LOW));
		plan.push_back(mk_note(0, 1, 1, 1, 127, 5));
		plan.push_back(mk_note(0, 1, 1, 0, 10, 0, EXP_GIVEN, 127, 5, 1, 1));
		plan.push_back(mk_cfg(1, 0, 127, MODE_HIGH));
		plan.push_back(mk_note(0, 1, 1, 1, 0, 9));
		plan.push_back(mk_note(0, 1, 1, 0, 127, 0, EXP_GIVEN, 0, 9, 1, 1));
		plan.push_back(mk_cfg(1, 0, 127, MODE_FIRST));
		plan.push_back(mk_note(0, 1, 1, 1, 50, 3));
		plan.push_back(mk_note(0, 1, 1, 1, 0, 100));
		plan.push_back(mk_cfg(1, 40, 60, MODE_FIRST));
		plan.push_back(mk_note(0, 1, 1, 1, 39, 7, EXP_NONE));
		plan.push_back(mk_note(0, 1, 1, 1, 61, 7, EXP_NONE));
		plan.push_back(mk_note(0, 1, 1, 0, 40, 7, EXP_NONE));
		plan.push_back(mk_note(0, 1, 1, 1, 60, 127));
		plan.push_back(mk_cfg(1, 70, 20, MODE_FIRST));
		plan.push_back(mk_note(0, 1, 1, 1, 70, 7, EXP_NONE));
		plan.push_back(mk_note(0, 1, 1, 1, 20, 7, EXP_NONE));
		plan.push_back(mk_note(1, 1, 1, 1, 50, 7, EXP_GIVEN, 50, 0, 0, 1));
		plan.push_back(mk_cfg(16, 0, 127, MODE_LAST));
		plan.push_back(mk_note(0, 1, 16, 1, 127, 0, EXP_GIVEN, 127, 0, 1, 0));
		plan.push_back(mk_note(0, 0, 16, 1, 30, 30, EXP_NONE));
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_config(plan[i].ch, plan[i].lo, plan[i].hi, plan[i].mode);
			else
				send_note(plan[i].n, plan[i].ek, plan[i].w);
		end
	endtask

	task automatic run_fill(mode_t mode);
		int order[HELD_MAX];
		int j;
		int tmp;
		note_t n;
		set_config(1, 0, 127, mode);
		calm = ($urandom_range(3, 0) == 0);
		for (int i = 0; i < HELD_MAX; i++)
			order[i] = i;
		for (int i = HELD_MAX - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < HELD_MAX; i++) begin
			n = '{vel: VEL_W'($urandom_range(127, 0)), key: KEY_W'(order[i]), on: 1'b1,
			      channel: 1, present: 1'b1, clear: 1'b0};
			send_note(n);
		end
		for (int i = 0; i < 40; i++) begin
			n = '{vel: VEL_W'($urandom_range(127, 0)), key: KEY_W'($urandom_range(127, 0)),
			      on: 1'($urandom_range(1, 0)), channel: 1, present: 1'b1, clear: 1'b0};
			send_note(n);
		end
		for (int i = 0; i < HELD_MAX; i++) begin
			n = '{vel: VEL_W'($urandom_range(127, 0)), key: KEY_W'(order[i]), on: 1'b0,
			      channel: 1, present: 1'b1, clear: 1'b0};
			send_note(n);
		end
	endtask

	task automatic run_phase(logic [CHAN_W-1:0] ch, logic [KEY_W-1:0] lo,
	                         logic [KEY_W-1:0] hi, mode_t mode, int count);
		logic [KEY_W-1:0] pool[8];
		note_t n;
		set_config(ch, lo, hi, mode);
		calm = ($urandom_range(3, 0) == 0);
		for (int i = 0; i < 8; i++)
			pool[i] = (lo <= hi) ? KEY_W'($urandom_range(hi, lo)) : KEY_W'($urandom_range(127, 0));
		if (lo <= hi) begin
			pool[0] = lo;
			pool[1] = hi;
		end
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99, 0) < 80) begin
				n.clear = ($urandom_range(39, 0) == 0);
				n.present = 1'b1;
				n.channel = ch;
				n.on = ($urandom_range(9, 0) < 6);
				n.key = pool[$urandom_range(7, 0)];
				n.vel = VEL_W'($urandom_range(127, 0));
			end else begin
				n = note_t'($urandom);
			end
			send_note(n);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= CFG_CHANNEL;
		cfg_wdata <= '0;
		errors = 0;
		burst_left = 0;
		calm = 0;
		reported_key = '0;
		reported_vel = '0;
		cur_channel = CHAN_RST;
		cur_low = KEY_LOW_RST;
		cur_high = KEY_HIGH_RST;
		cur_mode = MODE_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_phase(1, 0, 127, MODE_FIRST, 140);
		run_fill(mode_t'($urandom_range(3, 0)));
		run_phase(16, 0, 127, MODE_LAST, 140);
		run_phase(CHAN_W'($urandom_range(16, 1)), 0, 0, MODE_LOW, 100);
		run_phase(7, 127, 127, MODE_HIGH, 100);
		run_phase(CHAN_W'($urandom_range(16, 1)), 40, 90, MODE_LOW, 140);
		run_phase(CHAN_W'($urandom_range(16, 1)), 100, 20, MODE_FIRST, 60);
		run_phase(CHAN_W'($urandom_range(16, 1)), KEY_W'($urandom_range(63, 0)),
		          KEY_W'($urandom_range(127, 64)), MODE_HIGH, 140);
		run_phase(CHAN_W'($urandom_range(16, 1)), 0, 127, MODE_LAST, 140);

		wait_idle();
		if (errors == 0 && winner_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// hold off once for a long stretch so the block backs up into its input
	initial begin
		rx_style_t style;
		int span;
		int cyc;
		bit held_off;
		m_tready <= 1'b0;
		cyc = 0;
		held_off = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held_off && rx_count >= HOLD_AFTER) begin
				held_off = 1;
				repeat (LONG_HOLD) begin
					@(posedge clk);
					m_tready <= 1'b0;
				end
			end
			style = rx_style_t'($urandom_range(3, 0));
			span = $urandom_range(80, 10);
			repeat (span) begin
				@(posedge clk);
				cyc++;
				case (style)
					RX_OPEN:          m_tready <= 1'b1;
					RX_COIN:          m_tready <= 1'($urandom_range(1, 0));
					RX_THREE_OF_FOUR: m_tready <= (cyc % 4 != 0);
					RX_SPARSE:        m_tready <= ($urandom_range(3, 0) == 0);
				endcase
			end
		end
	end

	initial rx_count = 0;

	always @(posedge clk) begin
		winner_t got;
		winner_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = winner_t'(m_tdata);
			rx_count++;
			if (winner_q.size() == 0) begin
				report_mismatch("transaction count", 1, 0);
			end else begin
				want = winner_q.pop_front();
				if (got.key != want.key)
					report_mismatch("winner_key", int'(got.key), int'(want.key));
				if (got.vel != want.vel)
					report_mismatch("winner_velocity", int'(got.vel), int'(want.vel));
				if (got.key_chg != want.key_chg)
					report_mismatch("key_changed", int'(got.key_chg), int'(want.key_chg));
				if (got.vel_chg != want.vel_chg)
					report_mismatch("velocity_changed", int'(got.vel_chg), int'(want.vel_chg));
			end
		end
	end

endmodule
